@@ src/linear_probe_hash_table_macros.svh @@
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// Checks sampled on the rising clock edge and disabled while reset is active.
`define LPHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks sampled on the rising clock edge that also hold during reset.
`define LPHT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/lpht_pkg.sv @@
`default_nettype none

package lpht_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned KeyW       = 32;
  localparam int unsigned ValW       = 32;
  localparam int unsigned CntW       = 11;
  localparam int unsigned CapW       = 4;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned ModeW      = 2;

  typedef logic [KeyW-1:0]    key_t;
  typedef logic [ValW-1:0]    val_t;
  typedef logic [CntW-1:0]    cnt_t;
  typedef logic [CapW-1:0]    cap_t;
  typedef logic [AddrW-1:0]   addr_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [ModeW-1:0]   mode_t;

  localparam cap_t CapReset = cap_t'(4);

  localparam mode_t ModeInsert = mode_t'(0);
  localparam mode_t ModeLookup = mode_t'(1);
  localparam mode_t ModeDelete = mode_t'(2);
  localparam mode_t ModePop    = mode_t'(3);

  localparam status_t StatusDone     = status_t'(0);
  localparam status_t StatusPresent  = status_t'(1);
  localparam status_t StatusNotFound = status_t'(2);
  localparam status_t StatusFull     = status_t'(3);
  localparam status_t StatusKeyZero  = status_t'(4);

  // A capacity of zero acts as one; a capacity beyond the store saturates.
  function automatic addr_t slot_mask(cap_t cap);
    cap_t lg;
    lg = cap;
    if (lg == '0) begin
      lg = cap_t'(1);
    end
    if (lg > cap_t'(AddrW)) begin
      lg = cap_t'(AddrW);
    end
    return ~(addr_t'('1) << lg);
  endfunction

endpackage

`default_nettype wire

@@ src/lpht_intf.sv @@
`default_nettype none

interface lpht_in_if;
  logic                valid;
  logic                ready;
  lpht_pkg::mode_t     mode;
  lpht_pkg::key_t      key;
  lpht_pkg::val_t      value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink (input valid, input mode, input key, input value, output ready);
endinterface

interface lpht_out_if;
  logic                valid;
  logic                ready;
  lpht_pkg::status_t   status;
  logic                found;
  lpht_pkg::val_t      value_out;
  lpht_pkg::cnt_t      entry_count;

  modport source (output valid, output status, output found, output value_out,
                  output entry_count, input ready);
  modport sink (input valid, input status, input found, input value_out,
                input entry_count, output ready);
endinterface

interface lpht_cfg_if;
  logic                valid;
  logic                ready;
  lpht_pkg::cap_t      capacity_log2;

  modport source (output valid, output capacity_log2, input ready);
  modport sink (input valid, input capacity_log2, output ready);
endinterface

`default_nettype wire

@@ src/lpht_ram.sv @@
`default_nettype none

module lpht_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/linear_probe_hash_table.sv @@
// Open-addressing key/value table with linear probing.
// Channels: in_i carries one operation word (mode, key, value); out_o returns
// one result word (status, found, value_out, entry_count) for every operation;
// cfg_i writes capacity_log2 and is always ready. Write it only while idle.
// Keys and values sit in two single-port-read synchronous memories. Each
// probe step is one read of the key memory; the operation then passes
// through the done state, which loads the output register. A word with key
// zero skips the probe and goes straight to the done state. A new word is
// accepted once the previous result has been placed in the output register,
// so the block never takes a new word before it is through with the last.
// After reset the key memory is swept to empty, one slot per cycle, across
// all 1024 slots; in_i is not ready during the sweep, while cfg_i is.
// When the receiver stalls, a finished result waits in the output register
// and the next operation may already be accepted and probed; its own result
// then waits until the output register is free.
`default_nettype none

module linear_probe_hash_table (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lpht_in_if.sink   in_i,
  lpht_out_if.source out_o,
  lpht_cfg_if.sink  cfg_i
);

  import lpht_pkg::*;

`include "linear_probe_hash_table_macros.svh"

  typedef enum logic [3:0] {
    StClear = 4'b0001,
    StIdle  = 4'b0010,
    StCheck = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  state_e  state_q, state_d;
  cap_t    cap_q, cap_d;
  cnt_t    cnt_q, cnt_d;
  addr_t   clr_q, clr_d;
  logic    out_valid_q, out_valid_d;

  mode_t   mode_q, mode_d;
  key_t    key_q, key_d;
  val_t    val_q, val_d;
  addr_t   idx_q, idx_d;
  addr_t   step_q, step_d;
  status_t res_status_q, res_status_d;
  logic    res_found_q, res_found_d;
  val_t    res_val_q, res_val_d;
  status_t out_status_q, out_status_d;
  logic    out_found_q, out_found_d;
  val_t    out_val_q, out_val_d;
  cnt_t    out_cnt_q, out_cnt_d;

  addr_t   mask;
  addr_t   idx_nxt;
  addr_t   raddr;
  logic    key_we;
  addr_t   key_waddr;
  key_t    key_wdata;
  key_t    key_rdata;
  logic    val_we;
  val_t    val_rdata;
  logic    hit;
  logic    empty;
  logic    last;

  lpht_ram #(.Width(KeyW), .Depth(TableDepth)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (raddr),
    .rdata_o (key_rdata)
  );

  lpht_ram #(.Width(ValW), .Depth(TableDepth)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (idx_q),
    .wdata_i (val_q),
    .raddr_i (raddr),
    .rdata_o (val_rdata)
  );

  assign in_i.ready        = (state_q == StIdle);
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.found       = out_found_q;
  assign out_o.value_out   = out_val_q;
  assign out_o.entry_count = out_cnt_q;

  always_comb begin
    mask    = slot_mask(cap_q);
    idx_nxt = (idx_q + addr_t'(1)) & mask;
    hit     = (key_rdata == key_q);
    empty   = (key_rdata == '0);
    last    = (step_q == mask);

    state_d      = state_q;
    cap_d        = cap_q;
    cnt_d        = cnt_q;
    clr_d        = clr_q;
    out_valid_d  = out_valid_q;
    mode_d       = mode_q;
    key_d        = key_q;
    val_d        = val_q;
    idx_d        = idx_q;
    step_d       = step_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_val_d    = res_val_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_val_d    = out_val_q;
    out_cnt_d    = out_cnt_q;

    raddr     = idx_nxt;
    key_we    = 1'b0;
    key_waddr = idx_q;
    key_wdata = key_q;
    val_we    = 1'b0;

    if (cfg_i.valid) begin
      cap_d = cfg_i.capacity_log2;
    end

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StClear: begin
        key_we    = 1'b1;
        key_waddr = clr_q;
        key_wdata = '0;
        clr_d     = clr_q + addr_t'(1);
        if (clr_q == addr_t'(TableDepth - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        raddr = addr_t'(in_i.key) & mask;
        if (in_i.valid) begin
          mode_d    = in_i.mode;
          key_d     = in_i.key;
          val_d     = in_i.value;
          idx_d     = raddr;
          step_d    = '0;
          res_val_d = '0;
          if (in_i.key == '0) begin
            res_status_d = StatusKeyZero;
            res_found_d  = 1'b0;
            state_d      = StDone;
          end else begin
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        priority if (hit) begin
          res_found_d = 1'b1;
          if (mode_q == ModeInsert) begin
            res_status_d = StatusPresent;
          end else begin
            res_status_d = StatusDone;
            if (mode_q == ModeLookup || mode_q == ModePop) begin
              res_val_d = val_rdata;
            end
            if (mode_q == ModeDelete || mode_q == ModePop) begin
              key_we    = 1'b1;
              key_wdata = '0;
              if (cnt_q != '0) begin
                cnt_d = cnt_q - cnt_t'(1);
              end
            end
          end
          state_d = StDone;
        end else if (empty) begin
          if (mode_q == ModeInsert) begin
            key_we       = 1'b1;
            val_we       = 1'b1;
            cnt_d        = cnt_q + cnt_t'(1);
            res_status_d = StatusDone;
            res_found_d  = 1'b1;
          end else begin
            res_status_d = StatusNotFound;
            res_found_d  = 1'b0;
          end
          state_d = StDone;
        end else if (last) begin
          res_status_d = (mode_q == ModeInsert) ? StatusFull : StatusNotFound;
          res_found_d  = 1'b0;
          state_d      = StDone;
        end else begin
          idx_d  = idx_nxt;
          step_d = step_q + addr_t'(1);
        end
      end
      StDone: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          out_val_d    = res_val_q;
          out_cnt_d    = cnt_q;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      cap_q       <= CapReset;
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    key_q        <= key_d;
    val_q        <= val_d;
    idx_q        <= idx_d;
    step_q       <= step_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_val_q    <= res_val_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_val_q    <= out_val_d;
    out_cnt_q    <= out_cnt_d;
  end

  `LPHT_ASSERT(a_count_bound, cnt_q <= cnt_t'(TableDepth), "entry count beyond table depth")
  `LPHT_ASSERT(a_key_write_state,
               key_we |-> (state_q == StClear || state_q == StCheck), "stray key write")
  `LPHT_ASSERT(a_value_write_key, val_we |-> (key_we && key_wdata != '0), "stray value write")
  `LPHT_ASSERT(a_result_loaded,
               (state_q == StDone && state_d == StIdle) |=> out_valid_q, "result not loaded")
  `LPHT_ASSERT_ALWAYS(a_reset_quiet,
                      !rst_ni |=> (!out_valid_q || $past(rst_ni)), "result valid after reset")

endmodule

`default_nettype wire

@@ tb/linear_probe_hash_table_tb.sv @@
module linear_probe_hash_table_tb;
  import lpht_pkg::*;

  typedef struct packed {
    mode_t mode;
    key_t  key;
    val_t  value;
  } op_word_t;

  typedef struct packed {
    status_t status;
    logic    found;
    val_t    value_out;
    cnt_t    entry_count;
  } result_word_t;

  typedef enum int {ProbeExhausted, ProbeMatch, ProbeEmpty} probe_e;
  typedef enum int {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_e;

  localparam int WatchdogLimit = 20000;
  localparam int HeavyIdlePct  = 68;
  localparam int LightIdlePct  = 13;
  localparam int TailCycles    = 20;
  localparam int PhaseItems    = 108;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  lpht_in_if  in_if ();
  lpht_out_if out_if ();
  lpht_cfg_if cfg_if ();

  linear_probe_hash_table uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  key_t table_keys [TableDepth];
  val_t table_vals [TableDepth];
  cnt_t table_count;
  cap_t table_cap;

  op_word_t     pending_ops [$];
  result_word_t expected_results [$];
  key_t         key_pool [$];

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  word_taken;
  int  errors;
  int  ops_accepted;
  int  cap_writes;
  int  idle_cycles;
  int  status_seen [5];

  function automatic int unsigned slots_in_use();
    int unsigned lg;
    int unsigned n;
    lg = 32'(table_cap);
    if (lg == 0) begin
      lg = 1;
    end
    n = 1 << lg;
    while (n > TableDepth) begin
      n = n >> 1;
    end
    return n;
  endfunction

  function automatic result_word_t predict_op(op_word_t op);
    result_word_t r;
    int unsigned  n;
    int unsigned  idx;
    int unsigned  steps;
    probe_e       hit;
    r = '0;
    r.status = StatusDone;
    if (op.key == '0) begin
      r.status = StatusKeyZero;
    end else begin
      n = slots_in_use();
      idx = op.key & (n - 1);
      hit = ProbeExhausted;
      for (steps = 0; steps < n && hit == ProbeExhausted; steps++) begin
        if (table_keys[idx] == op.key) begin
          hit = ProbeMatch;
        end else if (table_keys[idx] == '0) begin
          hit = ProbeEmpty;
        end else begin
          idx = (idx + 1) & (n - 1);
        end
      end
      if (op.mode == ModeInsert) begin
        if (hit == ProbeMatch) begin
          r.status = StatusPresent;
          r.found = 1'b1;
        end else if (hit == ProbeEmpty) begin
          table_keys[idx] = op.key;
          table_vals[idx] = op.value;
          table_count = table_count + cnt_t'(1);
          r.found = 1'b1;
        end else begin
          r.status = StatusFull;
        end
      end else if (hit != ProbeMatch) begin
        r.status = StatusNotFound;
      end else begin
        r.found = 1'b1;
        if (op.mode == ModeLookup || op.mode == ModePop) begin
          r.value_out = table_vals[idx];
        end
        if (op.mode == ModeDelete || op.mode == ModePop) begin
          table_keys[idx] = '0;
          table_vals[idx] = '0;
          if (table_count != '0) begin
            table_count = table_count - cnt_t'(1);
          end
        end
      end
    end
    r.entry_count = table_count;
    return r;
  endfunction

  function automatic op_word_t random_op();
    op_word_t    op;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      op.mode = ModeInsert;
    end else if (pick < 65) begin
      op.mode = ModeLookup;
    end else if (pick < 80) begin
      op.mode = ModeDelete;
    end else begin
      op.mode = ModePop;
    end
    pick = $urandom_range(99);
    if (pick < 4) begin
      op.key = '0;
    end else if (pick < 8) begin
      op.key = $urandom;
    end else begin
      op.key = key_pool[$urandom_range(key_pool.size() - 1)];
    end
    pick = $urandom_range(9);
    if (pick == 0) begin
      op.value = '0;
    end else if (pick == 1) begin
      op.value = '1;
    end else begin
      op.value = $urandom;
    end
    return op;
  endfunction

  task automatic push_op(mode_t mode, key_t key, val_t value);
    pending_ops.push_back('{mode: mode, key: key, value: value});
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || in_if.valid || expected_results.size() != 0);
  endtask

  task automatic write_capacity(cap_t cap);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.capacity_log2 <= cap;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    table_cap = cap;
    cap_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_idling(idle_e mode);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    case (mode)
      IdleSender: begin
        send_idle_pct = HeavyIdlePct;
      end
      IdleReceiver: begin
        recv_stall_pct = HeavyIdlePct;
      end
      IdleBoth: begin
        send_idle_pct = LightIdlePct;
        recv_stall_pct = LightIdlePct;
      end
      default: begin
      end
    endcase
  endtask

  task automatic run_random_phase(cap_t cap, idle_e mode);
    int unsigned pool_size;
    key_t        k;
    write_capacity(cap);
    set_idling(mode);
    key_pool.delete();
    pool_size = 2 * slots_in_use() + 2;
    if (pool_size > 40) begin
      pool_size = 40;
    end
    while (key_pool.size() < pool_size) begin
      k = $urandom;
      if ($urandom_range(1) == 0) begin
        k[9:0] = 10'($urandom_range(15));
      end
      if (k == '0) begin
        k = 32'h8000_0000;
      end
      key_pool.push_back(k);
    end
    repeat (PhaseItems) begin
      pending_ops.push_back(random_op());
    end
  endtask

  always @(negedge clk_i) begin : drive_ops
    op_word_t op;
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!in_if.valid || word_taken) begin
      word_taken = 1'b0;
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        op = pending_ops.pop_front();
        in_if.valid <= 1'b1;
        in_if.mode  <= op.mode;
        in_if.key   <= op.key;
        in_if.value <= op.value;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    result_word_t want;
    bit           moved;
    moved = 1'b0;
    if (rst_ni && in_if.valid && in_if.ready) begin
      expected_results.push_back(predict_op('{mode: in_if.mode, key: in_if.key,
                                              value: in_if.value}));
      word_taken = 1'b1;
      ops_accepted++;
      moved = 1'b1;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      moved = 1'b1;
      if (expected_results.size() == 0) begin
        $error("result word arrived with no operation outstanding");
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_if.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_if.status);
          errors++;
        end
        if (out_if.found !== want.found) begin
          $error("found mismatch: expected %0d, got %0d", want.found, out_if.found);
          errors++;
        end
        if (out_if.value_out !== want.value_out) begin
          $error("value_out mismatch: expected %h, got %h", want.value_out, out_if.value_out);
          errors++;
        end
        if (out_if.entry_count !== want.entry_count) begin
          $error("entry_count mismatch: expected %0d, got %0d", want.entry_count,
                 out_if.entry_count);
          errors++;
        end
        if (out_if.status < 5) begin
          status_seen[out_if.status]++;
        end
      end
    end
    if (cfg_if.valid && cfg_if.ready) begin
      moved = 1'b1;
    end
    if (moved) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("linear_probe_hash_table_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    idle_e phase_idle [4];
    cap_t  phase_caps [12];
    phase_idle = '{IdleNone, IdleSender, IdleReceiver, IdleBoth};
    phase_caps = '{4'd3, 4'd1, 4'd5, 4'd2, 4'd10, 4'd4, 4'd0, 4'd6, 4'd15, 4'd3, 4'd7, 4'd2};
    in_if.valid = 1'b0;
    in_if.mode = ModeInsert;
    in_if.key = '0;
    in_if.value = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.capacity_log2 = CapReset;
    table_keys = '{default: '0};
    table_vals = '{default: '0};
    table_count = '0;
    table_cap = CapReset;
    status_seen = '{default: 0};
    set_idling(IdleNone);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // A two-slot table: key zero, filling up, repeats, misses and clearing.
    write_capacity(4'd1);
    push_op(ModeInsert, '0, 32'd1234);
    push_op(ModeLookup, '0, '0);
    push_op(ModeInsert, 32'h0000_0003, '1);
    push_op(ModeInsert, 32'hFFFF_FFFE, '0);
    push_op(ModeInsert, 32'h8000_0000, 32'hA5A5_A5A5);
    push_op(ModeInsert, 32'h0000_0003, 32'd7);
    push_op(ModeLookup, 32'h0000_0003, '0);
    push_op(ModeLookup, 32'h8000_0000, '0);
    push_op(ModeDelete, 32'hFFFF_FFFE, '0);
    push_op(ModePop, 32'h0000_0003, '0);
    push_op(ModeDelete, 32'h0000_0003, '0);
    push_op(ModePop, 32'hFFFF_FFFE, '0);

    // A capacity of zero behaves as a capacity of one.
    write_capacity(4'd0);
    push_op(ModeInsert, 32'h8000_0000, 32'h5A5A_5A5A);
    push_op(ModeLookup, 32'h8000_0000, '0);

    // Deleting from the middle of a chain strands the key behind it.
    write_capacity(4'd2);
    push_op(ModeInsert, 32'd4, 32'd4);
    push_op(ModeInsert, 32'd8, 32'd8);
    push_op(ModeInsert, 32'd12, 32'd12);
    push_op(ModeDelete, 32'd8, '0);
    push_op(ModeLookup, 32'd12, '0);
    push_op(ModeInsert, 32'd12, 32'hC0DE_0012);

    // The largest register value saturates to the full store.
    write_capacity(4'd15);
    push_op(ModeLookup, 32'd12, '0);
    push_op(ModeInsert, 32'hFFFF_FFFF, '1);
    push_op(ModePop, 32'hFFFF_FFFF, '0);

    for (int p = 0; p < 12; p++) begin
      run_random_phase(phase_caps[p], phase_idle[p % 4]);
    end

    wait_drained();
    repeat (TailCycles) @(negedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      errors++;
    end
    $display("Covered %0d operations across %0d capacity writes and four idling patterns.",
             ops_accepted, cap_writes);
    $display("Results: %0d done, %0d present, %0d not found, %0d full, %0d key zero.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0) begin
      $display("linear_probe_hash_table_tb OK");
    end else begin
      $display("linear_probe_hash_table_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ linear_probe_hash_table.f @@
+incdir+src
src/lpht_pkg.sv
src/lpht_intf.sv
src/lpht_ram.sv
src/linear_probe_hash_table.sv
tb/linear_probe_hash_table_tb.sv
